// ===== design/fdfir_pkg.sv =====
// ----------------------------------------------------------------------------
// fdfir_pkg
// Shared widths, register codes, control structs and FSM states for the
// fractional-derivative FIR.
// ----------------------------------------------------------------------------
package fdfir_pkg;

  localparam int TAPS      = 32;
  localparam int IDX_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int SMP_W     = 16;
  localparam int TAP_W     = 32;
  localparam int TIDX_W    = 5;
  localparam int OUT_W     = 48;
  localparam int PROD_W    = SMP_W + TAP_W;
  localparam int ACC_W     = PROD_W + IDX_W;
  localparam int FRAC_BITS = 16;
  localparam int RAW_W     = ACC_W - FRAC_BITS;
  localparam int SEL_W     = (IDX_W > TIDX_W) ? IDX_W : TIDX_W;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND  = CFG_IDX_W'(2);

  localparam logic REQ_SAMPLE   = 1'b0;
  localparam logic REQ_TAP_LOAD = 1'b1;

  // Per-cycle control broadcast along the cell row
  typedef struct packed {
    logic shift;   // advance the delay line by one sample
    logic rotate;  // circulate sample and tap pairs one cell over
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;   // zero the accumulator
    logic mul_en;  // multiply the pair at the tail of the row
  } mac_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } fsm_t;

endpackage

// ===== design/fdfir_cell.sv =====
// ----------------------------------------------------------------------------
// fdfir_cell
// One tap position: holds one history sample and one coefficient, takes its
// neighbor's sample on shift or both values on rotate; loads the tap on select.
// ----------------------------------------------------------------------------
module fdfir_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fdfir_pkg::cell_ctrl_t               ctrl,
  input  logic                                tap_sel,
  input  logic signed [fdfir_pkg::TAP_W-1:0]  tap_load,
  input  logic signed [fdfir_pkg::SMP_W-1:0]  smp_left,
  input  logic signed [fdfir_pkg::TAP_W-1:0]  tap_left,
  output logic signed [fdfir_pkg::SMP_W-1:0]  smp_q,
  output logic signed [fdfir_pkg::TAP_W-1:0]  tap_q
);

  logic signed [fdfir_pkg::SMP_W-1:0] smp_r, smp_nxt;
  logic signed [fdfir_pkg::TAP_W-1:0] tap_r, tap_nxt;

  always_comb begin
    smp_nxt = smp_r;
    tap_nxt = tap_r;
    if (ctrl.rotate) begin
      smp_nxt = smp_left;
      tap_nxt = tap_left;
    end else begin
      if (ctrl.shift) begin
        smp_nxt = smp_left;
      end
      if (tap_sel) begin
        tap_nxt = tap_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_r <= '0;
      tap_r <= '0;
    end else begin
      smp_r <= smp_nxt;
      tap_r <= tap_nxt;
    end
  end

  assign smp_q = smp_r;
  assign tap_q = tap_r;

endmodule

// ===== design/fdfir_mac.sv =====
// ----------------------------------------------------------------------------
// fdfir_mac
// Shared multiply-accumulate at the tail of the cell row: registered
// 16 x 32 product, then exact accumulation.
// ----------------------------------------------------------------------------
module fdfir_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fdfir_pkg::mac_ctrl_t                ctrl,
  input  logic signed [fdfir_pkg::SMP_W-1:0]  smp,
  input  logic signed [fdfir_pkg::TAP_W-1:0]  tap,
  output logic signed [fdfir_pkg::ACC_W-1:0]  acc
);

  logic signed [fdfir_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic                                prod_vld_r;
  logic signed [fdfir_pkg::ACC_W-1:0]  acc_r, acc_nxt;

  assign prod_nxt = fdfir_pkg::PROD_W'(smp) * fdfir_pkg::PROD_W'(tap);

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (prod_vld_r) begin
      acc_nxt = acc_r + fdfir_pkg::ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      prod_vld_r <= ctrl.mul_en;
      acc_r      <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== design/fractional_derivative_fir_top.sv =====
// ----------------------------------------------------------------------------
// fractional_derivative_fir_top
// FIR filter over a row of tap cells with one shared multiply-accumulate.
// ----------------------------------------------------------------------------
// A sample transaction runs from acceptance until its result is loaded into
// the output register as follows: the delay line shifts at the accepting
// edge, then the sample/coefficient pairs circulate once around the cell row
// past the single multiplier in the run state, the drain state lets the last
// product reach the accumulator, and the done state floors and clamps the
// sum and loads it. The next transaction is taken in the idle state after
// that load, so a sample is not taken before the last one's result is loaded.
// A coefficient-load transaction is taken only while idle and returns nothing.
// in_stall is high while a sample is in progress, and the finishing step
// waits while an earlier result is still held on a stalled output. No reset
// sweep is needed: all cells clear at reset.
// ----------------------------------------------------------------------------
module fractional_derivative_fir_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // configuration
  input  logic                                    cfg_we,
  input  logic [fdfir_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fdfir_pkg::CFG_W-1:0]             cfg_wdata,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_req_type,
  input  logic signed [fdfir_pkg::SMP_W-1:0]      in_sample,
  input  logic [fdfir_pkg::TIDX_W-1:0]            in_tap_index,
  input  logic signed [fdfir_pkg::TAP_W-1:0]      in_tap_value,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [fdfir_pkg::OUT_W-1:0]      out_filtered,
  output logic signed [fdfir_pkg::OUT_W-1:0]      out_unclamped,
  output logic                                    out_hit_upper,
  output logic                                    out_hit_lower
);

  // configuration registers
  logic                                clamp_en_r;
  logic signed [fdfir_pkg::OUT_W-1:0]  upper_r;
  logic signed [fdfir_pkg::OUT_W-1:0]  lower_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_en_r <= 1'b0;
      upper_r    <= {1'b0, {(fdfir_pkg::OUT_W-1){1'b1}}};
      lower_r    <= {1'b1, {(fdfir_pkg::OUT_W-1){1'b0}}};
    end else if (cfg_we) begin
      case (cfg_index)
        fdfir_pkg::REG_CLAMP_ENABLE: clamp_en_r <= cfg_wdata[0];
        fdfir_pkg::REG_UPPER_BOUND:  upper_r    <= cfg_wdata;
        fdfir_pkg::REG_LOWER_BOUND:  lower_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control
  fdfir_pkg::fsm_t                 state_r, state_nxt;
  logic [fdfir_pkg::IDX_W-1:0]     cnt_r, cnt_nxt;
  logic                            in_acc;
  logic                            smp_acc;
  logic                            tap_acc;
  logic                            run_last;
  logic                            out_free;
  fdfir_pkg::cell_ctrl_t           cell_ctrl;
  fdfir_pkg::mac_ctrl_t            mac_ctrl;
  logic                            result_ld;

  assign in_acc   = in_valid && !in_stall;
  assign smp_acc  = in_acc && (in_req_type == fdfir_pkg::REQ_SAMPLE);
  assign tap_acc  = in_acc && (in_req_type == fdfir_pkg::REQ_TAP_LOAD);
  assign run_last = (cnt_r == fdfir_pkg::IDX_W'(fdfir_pkg::TAPS - 1));
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fdfir_pkg::ST_IDLE:  if (smp_acc) state_nxt = fdfir_pkg::ST_RUN;
      fdfir_pkg::ST_RUN:   if (run_last) state_nxt = fdfir_pkg::ST_DRAIN;
      fdfir_pkg::ST_DRAIN: state_nxt = fdfir_pkg::ST_DONE;
      fdfir_pkg::ST_DONE:  if (out_free) state_nxt = fdfir_pkg::ST_IDLE;
      default:             state_nxt = fdfir_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall         = 1'b1;
    cell_ctrl.shift  = 1'b0;
    cell_ctrl.rotate = 1'b0;
    mac_ctrl.clear   = 1'b0;
    mac_ctrl.mul_en  = 1'b0;
    result_ld        = 1'b0;
    cnt_nxt          = cnt_r;
    case (state_r)
      fdfir_pkg::ST_IDLE: begin
        in_stall        = 1'b0;
        cell_ctrl.shift = smp_acc;
        mac_ctrl.clear  = smp_acc;
        cnt_nxt         = '0;
      end
      fdfir_pkg::ST_RUN: begin
        cell_ctrl.rotate = 1'b1;
        mac_ctrl.mul_en  = 1'b1;
        cnt_nxt          = cnt_r + fdfir_pkg::IDX_W'(1);
      end
      fdfir_pkg::ST_DRAIN: ;
      fdfir_pkg::ST_DONE: begin
        result_ld = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fdfir_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // cell row
  logic signed [fdfir_pkg::SMP_W-1:0] smp_q [fdfir_pkg::TAPS];
  logic signed [fdfir_pkg::TAP_W-1:0] tap_q [fdfir_pkg::TAPS];
  logic [fdfir_pkg::SEL_W-1:0]        tap_idx_ext;

  assign tap_idx_ext = fdfir_pkg::SEL_W'(in_tap_index);

  for (genvar k = 0; k < fdfir_pkg::TAPS; k++) begin : g_cell
    logic signed [fdfir_pkg::SMP_W-1:0] smp_left;
    logic signed [fdfir_pkg::TAP_W-1:0] tap_left;
    logic                               sel;

    if (k == 0) begin : g_head
      // the head takes the new sample on shift and the tail's pair on rotate
      assign smp_left = cell_ctrl.shift ? in_sample : smp_q[fdfir_pkg::TAPS-1];
      assign tap_left = tap_q[fdfir_pkg::TAPS-1];
    end else begin : g_body
      assign smp_left = smp_q[k-1];
      assign tap_left = tap_q[k-1];
    end

    // an index past the row matches no cell and the load is dropped
    assign sel = tap_acc && (tap_idx_ext == fdfir_pkg::SEL_W'(k));

    fdfir_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .tap_sel  (sel),
      .tap_load (in_tap_value),
      .smp_left (smp_left),
      .tap_left (tap_left),
      .smp_q    (smp_q[k]),
      .tap_q    (tap_q[k])
    );
  end

  // multiply-accumulate at the tail
  logic signed [fdfir_pkg::ACC_W-1:0] acc;

  fdfir_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .smp   (smp_q[fdfir_pkg::TAPS-1]),
    .tap   (tap_q[fdfir_pkg::TAPS-1]),
    .acc   (acc)
  );

  // floor shift and clamp
  logic signed [fdfir_pkg::RAW_W-1:0] raw_short;
  logic signed [fdfir_pkg::OUT_W-1:0] raw;
  logic signed [fdfir_pkg::OUT_W-1:0] res;
  logic                               hu, hl;

  assign raw_short = acc[fdfir_pkg::ACC_W-1:fdfir_pkg::FRAC_BITS];
  assign raw       = fdfir_pkg::OUT_W'(raw_short);

  always_comb begin
    res = raw;
    hu  = 1'b0;
    hl  = 1'b0;
    if (clamp_en_r) begin
      // upper first, then lower: crossed bounds end at the lower one
      if (raw > upper_r) begin
        res = upper_r;
        hu  = 1'b1;
      end
      if (res < lower_r) begin
        res = lower_r;
        hl  = 1'b1;
      end
    end
  end

  // output register
  logic                               out_valid_r, out_valid_nxt;
  logic signed [fdfir_pkg::OUT_W-1:0] filt_r, unclamp_r;
  logic                               hu_r, hl_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (result_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result_ld) begin
      filt_r    <= res;
      unclamp_r <= raw;
      hu_r      <= hu;
      hl_r      <= hl;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_filtered  = filt_r;
  assign out_unclamped = unclamp_r;
  assign out_hit_upper = hu_r;
  assign out_hit_lower = hl_r;

endmodule
